FILE: rtl/tptm_pkg.sv
`default_nettype none
package tptm_pkg;

	// The hop field is five bits wide, so the table covers every hop it can name.
	localparam int HOP_W = 5;
	localparam int HOP_SLOTS = 2 ** HOP_W;
	localparam logic [HOP_W-1:0] HOP_LAST = HOP_W'(HOP_SLOTS - 1);
	localparam logic [33:0] LONE_PREV_MARGIN = 34'd100000;
	localparam logic [1:0] TRY_SATURATE = 2'd3;
	localparam logic [7:0] KIND_ECHO_REPLY = 8'd0;
	localparam logic [7:0] KIND_TTL_EXPIRED = 8'd11;

	localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd500000;
	localparam logic [1:0] MAX_TRIES_RST = 2'd3;

	typedef enum logic [1:0] {
		CFG_DEFAULT_TIMEOUT = 2'd0,
		CFG_MAX_TRIES       = 2'd1,
		CFG_PROBE_IDENT     = 2'd2,
		CFG_TARGET_IP       = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_SEND   = 2'd0,
		REQ_REPLY  = 2'd1,
		REQ_EXPIRE = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		STAT_SENT      = 3'd0,
		STAT_RESENT    = 3'd1,
		STAT_EXHAUSTED = 3'd2,
		STAT_RECORDED  = 3'd3,
		STAT_IGNORED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_LOOK = 2'd1,
		ST_CALC = 2'd2,
		ST_WRAP = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		ALU_ADD_CAP  = 2'd0,
		ALU_SUB_SAT  = 2'd1,
		ALU_ADD_WRAP = 2'd2
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [33:0] a;
		logic [33:0] b;
		logic [31:0] cap;
	} alu_in_t;

endpackage
`default_nettype wire

FILE: rtl/tptm_if.sv
`default_nettype none
interface tptm_req_if import tptm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [HOP_W-1:0]  hop;
	logic [31:0]       now_us;
	logic [7:0]        reply_kind;
	logic              inner_is_icmp;
	logic [15:0]       inner_ident;
	logic [31:0]       responder_ip;

	modport source (output valid, req_type, hop, now_us, reply_kind, inner_is_icmp,
		inner_ident, responder_ip, input ready);
	modport sink (input valid, req_type, hop, now_us, reply_kind, inner_is_icmp,
		inner_ident, responder_ip, output ready);
endinterface

interface tptm_rsp_if import tptm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [HOP_W-1:0]  hop_out;
	logic [31:0]       deadline_us;
	logic [31:0]       timeout_us;
	logic [31:0]       rtt_us;
	logic              trace_done;
	logic [HOP_W-1:0]  last_hop;

	modport source (output valid, status, hop_out, deadline_us, timeout_us, rtt_us,
		trace_done, last_hop, input ready);
	modport sink (input valid, status, hop_out, deadline_us, timeout_us, rtt_us,
		trace_done, last_hop, output ready);
endinterface
`default_nettype wire

FILE: rtl/tptm_alu.sv
`default_nettype none
module tptm_alu import tptm_pkg::*; (
	input  alu_in_t     ctl,
	output logic [31:0] value
);

	logic [33:0] sum;

	always_comb begin
		if (ctl.op == ALU_SUB_SAT) begin
			sum = ctl.a + ~ctl.b + 34'd1;
		end else begin
			sum = ctl.a + ctl.b;
		end
		case (ctl.op)
			ALU_ADD_CAP: begin
				value = (sum > {2'b00, ctl.cap}) ? ctl.cap : sum[31:0];
			end
			// Operands are zero-extended, so bit 33 marks a negative difference.
			ALU_SUB_SAT: begin
				value = sum[33] ? 32'd0 : sum[31:0];
			end
			ALU_ADD_WRAP: begin
				value = sum[31:0];
			end
			default: begin
				value = sum[31:0];
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/traceroute_probe_timeout_manager.sv
`default_nettype none
// Per-hop probe table for a parallel traceroute.
// Items arrive on the req channel: a probe send, an arriving reply, or an
// expired hop deadline. Each item yields exactly one word on the rsp channel
// with its status, the chosen timeout and deadline for sends, the measured
// round trip for replies, and the trace's finish index and done flag.
// Configuration registers are written through cfg_wdata, cfg_idx and cfg_we; the user
// must write them only while no item is in flight. The block does not enforce this.
// The result is loaded into the output register after a look step that
// searches the replied hops and reads the round-trip and send-stamp
// memories, and two passes through the single shared adder (timeout or
// round trip, then deadline). The block is ready again the cycle after
// the load, so it accepts a new item only once the last result is loaded.
// If the receiver stalls, the result holds in the output register; the next
// item is still accepted and worked on, and waits in its last step until the
// output register frees up.
// Reset clears the answered and sent flags, try counters, finish index and
// done flag at once and restores the register defaults; there is no
// clearing pass.
module traceroute_probe_timeout_manager import tptm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	tptm_req_if.sink    req,
	tptm_rsp_if.source  rsp,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_idx,
	input  wire  [31:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [31:0] default_timeout_q;
	logic [1:0]  max_tries_q;
	logic [15:0] probe_ident_q;
	logic [31:0] target_ip_q;

	logic [1:0]       req_type_q;
	logic [HOP_W-1:0] hop_q;
	logic [31:0]      now_q;
	logic [7:0]       kind_q;
	logic             icmp_q;
	logic [15:0]      ident_q;
	logic [31:0]      resp_ip_q;

	logic [HOP_SLOTS-1:0] got_q;
	logic [HOP_SLOTS-1:0] sent_q;
	logic [1:0]           try_q [HOP_SLOTS];
	logic [HOP_W-1:0]     finish_q;
	logic                 done_q;

	logic [31:0] rt_mem [HOP_SLOTS];
	logic [31:0] stamp_mem [HOP_SLOTS];
	logic [31:0] rt_a_q, rt_b_q, stamp_q;

	logic p_ok_q, n_ok_q, far_ok_q, stamp_ok_q, match_q, go_q;
	logic [1:0] try_hop_q;
	logic [31:0] tmo_q, rtt_q;

	logic [2:0]       out_status_q;
	logic [HOP_W-1:0] out_hop_q;
	logic [31:0]      out_deadline_q, out_timeout_q, out_rtt_q;
	logic             out_done_q;
	logic [HOP_W-1:0] out_last_q;
	logic             out_valid_q;

	logic accept, load;
	logic [HOP_W-1:0] prev_idx, next_idx, far_idx, rd_a_idx;
	logic p_ok, n_ok, far_ok, match, go;
	logic [HOP_SLOTS-1:0] far_bits, far_low;
	alu_in_t alu_ctl;
	logic [31:0] alu_value;
	logic [2:0] status_d;
	logic [HOP_W-1:0] finish_d;
	logic done_d;

	assign accept = req.valid && req.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_timeout_q <= DEFAULT_TIMEOUT_RST;
			max_tries_q <= MAX_TRIES_RST;
			probe_ident_q <= '0;
			target_ip_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEFAULT_TIMEOUT: default_timeout_q <= cfg_wdata;
				CFG_MAX_TRIES:       max_tries_q <= cfg_wdata[1:0];
				CFG_PROBE_IDENT:     probe_ident_q <= cfg_wdata[15:0];
				CFG_TARGET_IP:       target_ip_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: state_d = ST_CALC;
			ST_CALC: state_d = ST_WRAP;
			ST_WRAP: begin
				if (!out_valid_q || rsp.ready) begin
					load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			hop_q <= req.hop;
			now_q <= req.now_us;
			kind_q <= req.reply_kind;
			icmp_q <= req.inner_is_icmp;
			ident_q <= req.inner_ident;
			resp_ip_q <= req.responder_ip;
		end
	end

	// Neighbor flags and the search for the nearest later replied hop.
	assign prev_idx = hop_q - HOP_W'(1);
	assign next_idx = hop_q + HOP_W'(1);
	assign p_ok = (hop_q != '0) && got_q[prev_idx];
	assign n_ok = (hop_q != HOP_LAST) && got_q[next_idx];

	always_comb begin
		for (int i = 0; i < HOP_SLOTS; i++) begin
			far_bits[i] = got_q[i] && ((HOP_W + 1)'(i) > ({1'b0, hop_q} + (HOP_W + 1)'(1)));
		end
		far_low = far_bits & (~far_bits + HOP_SLOTS'(1));
		far_idx = '0;
		for (int i = 0; i < HOP_SLOTS; i++) begin
			far_idx = far_idx | (far_low[i] ? HOP_W'(i) : '0);
		end
	end

	assign far_ok = |far_bits;
	assign rd_a_idx = p_ok ? prev_idx : far_idx;
	assign match = icmp_q && (ident_q == probe_ident_q)
		&& ((kind_q == KIND_ECHO_REPLY) || (kind_q == KIND_TTL_EXPIRED));
	assign go = (req_type_q == REQ_SEND)
		|| ((req_type_q == REQ_EXPIRE) && (try_q[hop_q] < max_tries_q));

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			rt_a_q <= rt_mem[rd_a_idx];
			rt_b_q <= rt_mem[next_idx];
			stamp_q <= stamp_mem[hop_q];
			p_ok_q <= p_ok;
			n_ok_q <= n_ok;
			far_ok_q <= far_ok;
			stamp_ok_q <= sent_q[hop_q];
			match_q <= match;
			go_q <= go;
			try_hop_q <= try_q[hop_q];
		end
	end

	// Operand selection for the shared adder.
	always_comb begin
		alu_ctl.cap = default_timeout_q;
		alu_ctl.op = ALU_ADD_CAP;
		alu_ctl.a = {2'b00, default_timeout_q};
		alu_ctl.b = '0;
		if (state_q == ST_WRAP) begin
			alu_ctl.op = ALU_ADD_WRAP;
			alu_ctl.a = {2'b00, now_q};
			alu_ctl.b = {2'b00, tmo_q};
		end else if (req_type_q == REQ_REPLY) begin
			alu_ctl.op = ALU_SUB_SAT;
			alu_ctl.a = {2'b00, now_q};
			alu_ctl.b = stamp_ok_q ? {2'b00, stamp_q} : '0;
		end else if (p_ok_q && n_ok_q) begin
			alu_ctl.a = {2'b00, rt_a_q};
			alu_ctl.b = {2'b00, rt_b_q};
		end else if (n_ok_q) begin
			alu_ctl.a = {1'b0, rt_b_q, 1'b0};
		end else if (p_ok_q) begin
			alu_ctl.a = {1'b0, rt_a_q, 1'b0};
			alu_ctl.b = LONE_PREV_MARGIN;
		end else if (far_ok_q) begin
			alu_ctl.a = {1'b0, rt_a_q, 1'b0};
		end
	end

	tptm_alu u_alu (
		.ctl   (alu_ctl),
		.value (alu_value)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			tmo_q <= alu_value;
			rtt_q <= alu_value;
		end
	end

	always_comb begin
		finish_d = finish_q;
		done_d = done_q;
		if (hop_q > finish_q) begin
			finish_d = hop_q;
		end
		if ((resp_ip_q == target_ip_q) || (hop_q == HOP_LAST)) begin
			finish_d = hop_q;
			done_d = 1'b1;
		end
	end

	// Reply bookkeeping is committed in the calculate step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_q <= '0;
			finish_q <= '0;
			done_q <= 1'b0;
		end else if (state_q == ST_CALC && req_type_q == REQ_REPLY && match_q) begin
			got_q[hop_q] <= 1'b1;
			finish_q <= finish_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && req_type_q == REQ_REPLY && match_q) begin
			rt_mem[hop_q] <= alu_value;
		end
	end

	// Send bookkeeping is committed when the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
			try_q <= '{default: '0};
		end else if (load && req_type_q != REQ_REPLY && go_q) begin
			sent_q[hop_q] <= 1'b1;
			if (try_hop_q < TRY_SATURATE) begin
				try_q[hop_q] <= try_hop_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && req_type_q != REQ_REPLY && go_q) begin
			stamp_mem[hop_q] <= now_q;
		end
	end

	always_comb begin
		case (req_type_q)
			REQ_SEND:   status_d = STAT_SENT;
			REQ_EXPIRE: status_d = go_q ? STAT_RESENT : STAT_EXHAUSTED;
			REQ_REPLY:  status_d = match_q ? STAT_RECORDED : STAT_IGNORED;
			default:    status_d = STAT_IGNORED;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= status_d;
			out_hop_q <= hop_q;
			if ((status_d == STAT_SENT) || (status_d == STAT_RESENT)) begin
				out_deadline_q <= alu_value;
				out_timeout_q <= tmo_q;
			end else begin
				out_deadline_q <= '0;
				out_timeout_q <= '0;
			end
			out_rtt_q <= (status_d == STAT_RECORDED) ? rtt_q : '0;
			out_done_q <= done_q;
			out_last_q <= finish_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.hop_out = out_hop_q;
	assign rsp.deadline_us = out_deadline_q;
	assign rsp.timeout_us = out_timeout_q;
	assign rsp.rtt_us = out_rtt_q;
	assign rsp.trace_done = out_done_q;
	assign rsp.last_hop = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/tptm_checker.sv
`default_nettype none
module tptm_checker import tptm_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              req_valid,
	input wire              req_ready,
	input wire              rsp_valid,
	input wire              rsp_ready,
	input wire  [2:0]       rsp_status,
	input wire  [31:0]      rsp_deadline_us,
	input wire  [31:0]      rsp_timeout_us,
	input wire  [31:0]      rsp_rtt_us
);

	// A word that is not taken stays offered with the same status.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("stalled response word changed or dropped");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new item accepted while one is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STAT_SENT) && (rsp_status != STAT_RESENT)
		|-> (rsp_deadline_us == '0) && (rsp_timeout_us == '0))
		else $error("timing fields set on a non-send result");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STAT_RECORDED) |-> (rsp_rtt_us == '0))
		else $error("round trip set on a result that records no reply");

endmodule

bind traceroute_probe_timeout_manager tptm_checker u_tptm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_deadline_us (rsp.deadline_us),
	.rsp_timeout_us  (rsp.timeout_us),
	.rsp_rtt_us      (rsp.rtt_us)
);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import tptm_pkg::*;

	localparam int CLK_HALF_NS = 6;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1650;
	localparam int TRAFFIC_PHASES = 5;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [33:0] LONE_PREV_EXTRA_US = 34'd100000;
	localparam logic [1:0] TRIES_CEILING = 2'd3;
	localparam logic [31:0] HOP_GATEWAY_ADDR = 32'h0A00_0001;

	typedef struct packed {
		logic [1:0]       code;
		logic [HOP_W-1:0] hop;
		logic [31:0]      now_us;
		logic [7:0]       reply_kind;
		logic             inner_is_icmp;
		logic [15:0]      inner_ident;
		logic [31:0]      responder_ip;
	} probe_event_t;

	typedef struct packed {
		status_t          status;
		logic [HOP_W-1:0] hop;
		logic [31:0]      deadline_us;
		logic [31:0]      timeout_us;
		logic [31:0]      rtt_us;
		logic             trace_done;
		logic [HOP_W-1:0] last_hop;
	} probe_outcome_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	tptm_req_if req_ch ();
	tptm_rsp_if rsp_ch ();

	traceroute_probe_timeout_manager i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Register copies and per-hop table as the block should hold them.
	logic [31:0]      rto_cap;
	logic [1:0]       try_limit;
	logic [15:0]      my_ident;
	logic [31:0]      dest_ip;
	bit               hop_answered [HOP_SLOTS];
	logic [31:0]      hop_rtt [HOP_SLOTS];
	logic [31:0]      hop_sent_at [HOP_SLOTS];
	logic [1:0]       hop_tries [HOP_SLOTS];
	logic [HOP_W-1:0] trace_end;
	bit               trace_over;

	probe_event_t   probe_events [$];
	probe_outcome_t pending_outcomes [$];
	int             driven_count;
	int             taken_count;
	int             mismatches;
	int             src_gap;
	int             src_calm;
	int             snk_stall;
	int             snk_calm;
	logic [31:0]    stim_clock_us;

	always #CLK_HALF_NS clk = ~clk;

	function automatic logic [31:0] clip_rto(input logic [33:0] wide);
		return (wide > {2'b00, rto_cap}) ? rto_cap : wide[31:0];
	endfunction

	// Neighbours first, then the nearest later hop that has answered.
	function automatic logic [31:0] pick_rto(input logic [HOP_W-1:0] h);
		int hi;
		bit prev_ok;
		bit next_ok;
		hi = int'(h);
		prev_ok = (hi > 0) && hop_answered[hi - 1];
		next_ok = (hi < HOP_SLOTS - 1) && hop_answered[hi + 1];
		if (prev_ok && next_ok)
			return clip_rto({2'b00, hop_rtt[hi - 1]} + {2'b00, hop_rtt[hi + 1]});
		if (next_ok)
			return clip_rto({2'b00, hop_rtt[hi + 1]} << 1);
		if (prev_ok)
			return clip_rto(({2'b00, hop_rtt[hi - 1]} << 1) + LONE_PREV_EXTRA_US);
		for (int k = hi + 2; k < HOP_SLOTS; k++) begin
			if (hop_answered[k])
				return clip_rto({2'b00, hop_rtt[k]} << 1);
		end
		return rto_cap;
	endfunction

	function automatic probe_outcome_t probe_table_step(input probe_event_t ev);
		probe_outcome_t res;
		logic [31:0] rto;
		res = '0;
		res.status = STAT_IGNORED;
		res.hop = ev.hop;
		if (ev.code == REQ_SEND || ev.code == REQ_EXPIRE) begin
			if (ev.code == REQ_EXPIRE && hop_tries[ev.hop] >= try_limit) begin
				res.status = STAT_EXHAUSTED;
			end else begin
				rto = pick_rto(ev.hop);
				hop_sent_at[ev.hop] = ev.now_us;
				res.timeout_us = rto;
				res.deadline_us = ev.now_us + rto;
				if (hop_tries[ev.hop] < TRIES_CEILING)
					hop_tries[ev.hop] = hop_tries[ev.hop] + 2'd1;
				res.status = (ev.code == REQ_SEND) ? STAT_SENT : STAT_RESENT;
			end
		end else if (ev.code == REQ_REPLY && ev.inner_is_icmp && ev.inner_ident == my_ident &&
				(ev.reply_kind == KIND_ECHO_REPLY || ev.reply_kind == KIND_TTL_EXPIRED)) begin
			res.rtt_us = (ev.now_us >= hop_sent_at[ev.hop]) ? ev.now_us - hop_sent_at[ev.hop] : '0;
			hop_rtt[ev.hop] = res.rtt_us;
			hop_answered[ev.hop] = 1'b1;
			if (ev.hop > trace_end)
				trace_end = ev.hop;
			if (ev.responder_ip == dest_ip || ev.hop == HOP_LAST) begin
				trace_end = ev.hop;
				trace_over = 1'b1;
			end
			res.status = STAT_RECORDED;
		end
		res.trace_done = trace_over;
		res.last_hop = trace_end;
		return res;
	endfunction

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	task automatic queue_event(input logic [1:0] code, input logic [HOP_W-1:0] hop,
			input logic [31:0] at_us, input logic [7:0] kind, input logic icmp,
			input logic [15:0] ident, input logic [31:0] src);
		probe_event_t ev;
		ev = '{code: code, hop: hop, now_us: at_us, reply_kind: kind, inner_is_icmp: icmp,
			inner_ident: ident, responder_ip: src};
		probe_events.push_back(ev);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		case (idx)
			CFG_DEFAULT_TIMEOUT: rto_cap = value;
			CFG_MAX_TRIES:       try_limit = value[1:0];
			CFG_PROBE_IDENT:     my_ident = value[15:0];
			CFG_TARGET_IP:       dest_ip = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic settle();
		while (probe_events.size() != 0 || taken_count != driven_count ||
				pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly complete probe lifetimes: a send, maybe some resends after expiry, then
	// usually a matching reply. The rest are near-miss replies and raw noise.
	task automatic gen_traffic(input int quota, input int reply_floor);
		int added;
		int pick;
		int resends;
		logic [HOP_W-1:0] h;
		logic [31:0] stamp;
		logic [31:0] heard_at;
		logic [7:0] kind;
		logic [7:0] bad_kind;
		added = 0;
		while (added < quota) begin
			stim_clock_us += $urandom_range(0, 5000);
			if ($urandom_range(0, 39) == 0)
				stim_clock_us = $urandom;
			h = HOP_W'($urandom_range(0, HOP_SLOTS - 1));
			kind = $urandom_range(0, 1) ? KIND_ECHO_REPLY : KIND_TTL_EXPIRED;
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				queue_event(REQ_SEND, h, stim_clock_us, 8'($urandom), 1'($urandom),
					16'($urandom), $urandom);
				added++;
				resends = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				repeat (resends) begin
					stim_clock_us += $urandom_range(1000, 600000);
					queue_event(REQ_EXPIRE, h, stim_clock_us, 8'($urandom), 1'($urandom),
						16'($urandom), $urandom);
					added++;
				end
				stamp = stim_clock_us;
				if (h >= reply_floor && $urandom_range(0, 9) < 7) begin
					pick = $urandom_range(0, 9);
					if (pick < 8)
						heard_at = stamp + $urandom_range(500, 250000);
					else if (pick < 9)
						heard_at = stamp + $urandom;
					else
						heard_at = stamp - $urandom_range(1, 5000);
					queue_event(REQ_REPLY, h, heard_at, kind, 1'b1, my_ident,
						($urandom_range(0, 9) == 0) ? dest_ip : $urandom);
					added++;
					if (pick < 9)
						stim_clock_us = heard_at;
				end
			end else if (pick < 80) begin
				bad_kind = 8'($urandom_range(1, 255));
				if (bad_kind == KIND_TTL_EXPIRED)
					bad_kind = KIND_TTL_EXPIRED + 8'd1;
				pick = $urandom_range(0, 2);
				queue_event(REQ_REPLY, h, stim_clock_us, (pick == 0) ? bad_kind : kind,
					pick != 1, (pick == 2) ? my_ident ^ 16'($urandom_range(1, 65535)) : my_ident,
					$urandom);
				added++;
			end else begin
				queue_event(2'($urandom_range(0, 3)), HOP_W'($urandom), $urandom, 8'($urandom),
					1'($urandom), 16'($urandom), $urandom);
				added++;
			end
		end
	endtask

	task automatic compare_field(input string field, input logic [HOP_W-1:0] hop,
			input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < REPORT_LIMIT)
				$display("hop %0d %s: expected %0h, got %0h", hop, field, want, got);
			mismatches++;
		end
	endtask

	task automatic check_word(input probe_outcome_t want);
		compare_field("status", want.hop, 32'(want.status), 32'(rsp_ch.status));
		compare_field("hop_out", want.hop, 32'(want.hop), 32'(rsp_ch.hop_out));
		compare_field("deadline_us", want.hop, want.deadline_us, rsp_ch.deadline_us);
		compare_field("timeout_us", want.hop, want.timeout_us, rsp_ch.timeout_us);
		compare_field("rtt_us", want.hop, want.rtt_us, rsp_ch.rtt_us);
		compare_field("trace_done", want.hop, 32'(want.trace_done), 32'(rsp_ch.trace_done));
		compare_field("last_hop", want.hop, 32'(want.last_hop), 32'(rsp_ch.last_hop));
	endtask

	// Request driver: a word stays on the bus until the monitor has counted it taken.
	always @(negedge clk) begin
		probe_event_t ev;
		if (req_ch.valid && taken_count != driven_count) begin
		end else if (src_gap > 0) begin
			src_gap--;
			req_ch.valid <= 1'b0;
		end else if (arst_n && probe_events.size() != 0) begin
			ev = probe_events.pop_front();
			driven_count++;
			req_ch.valid <= 1'b1;
			req_ch.req_type <= ev.code;
			req_ch.hop <= ev.hop;
			req_ch.now_us <= ev.now_us;
			req_ch.reply_kind <= ev.reply_kind;
			req_ch.inner_is_icmp <= ev.inner_is_icmp;
			req_ch.inner_ident <= ev.inner_ident;
			req_ch.responder_ip <= ev.responder_ip;
			if (src_calm > 0) begin
				src_calm--;
			end else begin
				src_gap = idle_span();
				if ($urandom_range(0, 49) == 0)
					src_calm = $urandom_range(20, 100);
			end
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (snk_stall > 0) begin
			snk_stall--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (snk_calm > 0)
				snk_calm--;
			else if ($urandom_range(0, 3) == 0)
				snk_stall = idle_span();
			else if ($urandom_range(0, 59) == 0)
				snk_calm = $urandom_range(20, 100);
		end
	end

	always @(posedge clk) begin
		probe_event_t seen;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			seen = '{code: req_ch.req_type, hop: req_ch.hop, now_us: req_ch.now_us,
				reply_kind: req_ch.reply_kind, inner_is_icmp: req_ch.inner_is_icmp,
				inner_ident: req_ch.inner_ident, responder_ip: req_ch.responder_ip};
			pending_outcomes.push_back(probe_table_step(seen));
			taken_count++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("word with nothing expected: status %0d hop %0d", rsp_ch.status,
						rsp_ch.hop_out);
				mismatches++;
			end else begin
				check_word(pending_outcomes.pop_front());
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_DEFAULT_TIMEOUT;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SEND;
		req_ch.hop = '0;
		req_ch.now_us = '0;
		req_ch.reply_kind = '0;
		req_ch.inner_is_icmp = 1'b0;
		req_ch.inner_ident = '0;
		req_ch.responder_ip = '0;
		rsp_ch.ready = 1'b0;
		rto_cap = DEFAULT_TIMEOUT_RST;
		try_limit = MAX_TRIES_RST;
		my_ident = '0;
		dest_ip = '0;
		for (int i = 0; i < HOP_SLOTS; i++) begin
			hop_answered[i] = 1'b0;
			hop_rtt[i] = '0;
			hop_sent_at[i] = '0;
			hop_tries[i] = '0;
		end
		trace_end = '0;
		trace_over = 1'b0;
		stim_clock_us = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under the reset register values. Each timeout source is hit
		// in turn: nothing answered, a far later hop, next only, previous only, both.
		queue_event(REQ_SEND, 5'd5, 32'd1000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_REPLY, 5'd20, 32'd40000, KIND_TTL_EXPIRED, 1'b1, 16'd0,
			HOP_GATEWAY_ADDR);
		queue_event(REQ_SEND, 5'd5, 32'd50000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_REPLY, 5'd6, 32'd60000, KIND_ECHO_REPLY, 1'b1, 16'd0, HOP_GATEWAY_ADDR);
		queue_event(REQ_SEND, 5'd5, 32'd70000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_SEND, 5'd5, 32'd71000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_EXPIRE, 5'd5, 32'd72000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_SEND, 5'd7, 32'd100000, 8'd0, 1'b0, 16'd0, 32'd0);
		// A reply stamped before its send gives a zero round trip.
		queue_event(REQ_REPLY, 5'd7, 32'd90000, KIND_ECHO_REPLY, 1'b1, 16'd0, HOP_GATEWAY_ADDR);
		queue_event(REQ_REPLY, 5'd4, 32'd30000, KIND_ECHO_REPLY, 1'b1, 16'd0, HOP_GATEWAY_ADDR);
		queue_event(REQ_SEND, 5'd5, 32'd110000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_EXPIRE, 5'd9, 32'd120000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_SEND, 5'd0, 32'd130000, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_SEND, HOP_LAST, 32'hFFFF_FF00, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_REPLY, 5'd10, 32'd140000, KIND_ECHO_REPLY, 1'b0, 16'd0,
			HOP_GATEWAY_ADDR);
		queue_event(REQ_REPLY, 5'd10, 32'd140000, KIND_ECHO_REPLY, 1'b1, 16'hFFFF,
			32'hFFFF_FFFF);
		queue_event(REQ_REPLY, 5'd10, 32'd140000, 8'd3, 1'b1, 16'd0, HOP_GATEWAY_ADDR);
		queue_event(REQ_REPLY, 5'd10, 32'd140000, 8'hFF, 1'b1, 16'd0, HOP_GATEWAY_ADDR);
		queue_event(REQ_UNUSED, HOP_LAST, 32'hFFFF_FFFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
		queue_event(REQ_REPLY, HOP_LAST, 32'hFFFF_FFFF, KIND_TTL_EXPIRED, 1'b1, 16'd0,
			HOP_GATEWAY_ADDR);
		// Largest round trip, so that every sum built on it runs into the cap.
		queue_event(REQ_REPLY, 5'd12, 32'hFFFF_FFFF, KIND_ECHO_REPLY, 1'b1, 16'd0,
			HOP_GATEWAY_ADDR);
		queue_event(REQ_SEND, 5'd11, 32'd0, 8'd0, 1'b0, 16'd0, 32'd0);
		queue_event(REQ_REPLY, 5'd3, 32'd5000, KIND_ECHO_REPLY, 1'b1, 16'd0, 32'd0);
		queue_event(REQ_SEND, 5'd13, 32'd200, 8'd0, 1'b0, 16'd0, 32'd0);

		for (int ph = 1; ph <= TRAFFIC_PHASES; ph++) begin
			settle();
			case (ph)
				1: begin
					write_reg(CFG_DEFAULT_TIMEOUT, 32'hFFFF_FFFF);
					write_reg(CFG_MAX_TRIES, 32'd1);
					write_reg(CFG_PROBE_IDENT, 32'h0000_FFFF);
					write_reg(CFG_TARGET_IP, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CFG_DEFAULT_TIMEOUT, 32'd0);
					write_reg(CFG_MAX_TRIES, 32'd2);
					write_reg(CFG_PROBE_IDENT, $urandom);
					write_reg(CFG_TARGET_IP, $urandom);
				end
				3: begin
					write_reg(CFG_DEFAULT_TIMEOUT, $urandom_range(50000, 400000));
					write_reg(CFG_MAX_TRIES, 32'd0);
					write_reg(CFG_PROBE_IDENT, 32'h0000_5A5A);
					write_reg(CFG_TARGET_IP, 32'd0);
				end
				4: begin
					write_reg(CFG_DEFAULT_TIMEOUT, DEFAULT_TIMEOUT_RST);
					write_reg(CFG_MAX_TRIES, 32'd3);
					write_reg(CFG_PROBE_IDENT, 32'd0);
					write_reg(CFG_TARGET_IP, $urandom);
				end
				default: begin
					write_reg(CFG_DEFAULT_TIMEOUT, $urandom);
					write_reg(CFG_MAX_TRIES, $urandom_range(1, 3));
					write_reg(CFG_PROBE_IDENT, $urandom);
					write_reg(CFG_TARGET_IP, $urandom);
				end
			endcase
			// The first phase answers only the upper hops, so low hops keep using the
			// search for a later replied hop.
			gen_traffic(RANDOM_ITEMS / TRAFFIC_PHASES, (ph == 1) ? HOP_SLOTS / 2 : 0);
		end
		settle();

		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
